[hw/rtl/mvt_pkg.sv]
`default_nettype none

package mvt_pkg;

    // Element and lane geometry
    localparam int LANES     = 4;
    localparam int COL_W     = $clog2(LANES);
    localparam int ELEM_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int SUM_W     = PROD_W + COL_W;
    // Bits of the shifted sum that must all agree for the value to fit
    localparam int HEAD_W    = SUM_W - ELEM_W + 1;

    // Item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_XFORM = 1'b1;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef t_elem [LANES-1:0]        t_vec;

    localparam t_elem ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam t_elem ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    typedef struct packed {
        logic en_prod;
        logic en_sum;
    } t_lane_ctrl;

    typedef struct packed {
        t_elem value;
        logic  clip;
    } t_lane_res;

    typedef struct packed {
        t_vec results;
        logic saturated;
    } t_out_word;

endpackage

`default_nettype wire

[hw/rtl/mvt_in_if.sv]
`default_nettype none

interface mvt_in_if;
    import mvt_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic [COL_W-1:0]   column_index;
    t_elem              value_0;
    t_elem              value_1;
    t_elem              value_2;
    t_elem              value_3;

    modport source (
        output valid, kind, column_index, value_0, value_1, value_2, value_3,
        input  ready
    );

    modport sink (
        input  valid, kind, column_index, value_0, value_1, value_2, value_3,
        output ready
    );

endinterface

`default_nettype wire

[hw/rtl/mvt_out_if.sv]
`default_nettype none

interface mvt_out_if;
    import mvt_pkg::*;

    logic   valid;
    logic   ready;
    t_elem  result_0;
    t_elem  result_1;
    t_elem  result_2;
    t_elem  result_3;
    logic   saturated;

    modport source (
        output valid, result_0, result_1, result_2, result_3, saturated,
        input  ready
    );

    modport sink (
        input  valid, result_0, result_1, result_2, result_3, saturated,
        output ready
    );

endinterface

`default_nettype wire

[hw/rtl/mvt_lane.sv]
`default_nettype none

// One matrix row: four products, their exact sum, then shift and clip.
module mvt_lane (
    input  wire logic               i_clk,
    input  wire mvt_pkg::t_lane_ctrl i_ctrl,
    input  wire mvt_pkg::t_vec      i_coef,
    input  wire mvt_pkg::t_vec      i_vec,
    output mvt_pkg::t_lane_res      o_res
);
    import mvt_pkg::*;

    t_prod              r_prod [LANES];
    t_sum               r_sum;
    t_sum               n_sum;
    t_sum               w_shift;
    logic [HEAD_W-1:0]  w_head;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_prod) begin
            for (int c = 0; c < LANES; c++) begin
                r_prod[c] <= $signed(i_coef[c]) * $signed(i_vec[c]);
            end
        end
        if (i_ctrl.en_sum) begin
            r_sum <= n_sum;
        end
    end

    always_comb begin
        n_sum = '0;
        for (int c = 0; c < LANES; c++) begin
            n_sum = n_sum + SUM_W'(r_prod[c]);
        end
    end

    // Arithmetic shift rounds toward minus infinity
    assign w_shift = r_sum >>> FRAC_BITS;
    assign w_head  = w_shift[SUM_W-1 -: HEAD_W];

    always_comb begin
        if ((&w_head) || !(|w_head)) begin
            o_res.value = w_shift[ELEM_W-1:0];
            o_res.clip  = 1'b0;
        end else if (w_head[HEAD_W-1]) begin
            o_res.value = ELEM_MIN;
            o_res.clip  = 1'b1;
        end else begin
            o_res.value = ELEM_MAX;
            o_res.clip  = 1'b1;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/mvt_merge.sv]
`default_nettype none

// Gather the lane results into one output word and combine the clip flags.
module mvt_merge (
    input  wire mvt_pkg::t_lane_res i_res [mvt_pkg::LANES],
    output mvt_pkg::t_out_word      o_word
);
    import mvt_pkg::*;

    always_comb begin
        o_word.saturated = 1'b0;
        for (int r = 0; r < LANES; r++) begin
            o_word.results[r] = i_res[r].value;
            o_word.saturated  = o_word.saturated | i_res[r].clip;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/matrix_vector_transform_4x4.sv]
`default_nettype none

// 4x4 matrix-vector transform, signed Q16.16.
//
// Channels: i_in carries items (valid/ready). kind = load writes value_0..3
// into column column_index of the stored matrix and yields no result.
// kind = transform multiplies the stored matrix by the vector value_0..3;
// o_out then carries result_0..3 (each sum shifted right by 16, rounding
// toward minus infinity, clipped to 32 bits) and saturated, set when any
// element was clipped.
// Pipeline: a transform passes the product register, the sum register and
// the output register, in that order, before it is presented on o_out.
// Throughput: one item per cycle while o_out.ready is high, set by the four
// row lanes of four multipliers each, all sixteen working in parallel.
// A load is visible to a transform accepted in the very next cycle.
// Reset: clears the matrix to zero and empties the pipeline.
// Stall: when o_out.ready is low the output register holds its result;
// earlier stages keep filling until each holds an item, and only then does
// i_in.ready drop.
module matrix_vector_transform_4x4_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mvt_in_if.sink      i_in,
    mvt_out_if.source   o_out
);
    import mvt_pkg::*;

    // Stored matrix, one packed column per entry
    t_vec       r_matrix [LANES];
    t_vec       w_coef   [LANES];
    t_vec       w_vec;

    logic       r_s1_valid;
    logic       r_s2_valid;
    logic       r_out_valid;
    t_out_word  r_out_data;

    logic       w_fire;
    logic       w_out_free;
    logic       w_s2_free;
    logic       w_s2_adv;
    logic       w_s1_free;
    logic       w_s1_adv;

    t_lane_ctrl w_ctrl;
    t_lane_res  w_res [LANES];
    t_out_word  w_word;

    // Elastic pipeline: a stage takes new data when empty or when it drains
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_s2_adv   = r_s2_valid && w_out_free;
    assign w_s2_free  = !r_s2_valid || w_out_free;
    assign w_s1_adv   = r_s1_valid && w_s2_free;
    assign w_s1_free  = !r_s1_valid || w_s2_free;

    assign i_in.ready = w_s1_free;
    assign w_fire     = i_in.valid && i_in.ready;

    assign w_vec = {i_in.value_3, i_in.value_2, i_in.value_1, i_in.value_0};

    // Lane r sees element r of every column
    always_comb begin
        for (int r = 0; r < LANES; r++) begin
            for (int c = 0; c < LANES; c++) begin
                w_coef[r][c] = r_matrix[c][r];
            end
        end
    end

    // Capture products only for an accepted transform
    assign w_ctrl.en_prod = w_fire && (i_in.kind == KIND_XFORM);
    assign w_ctrl.en_sum  = w_s1_adv;

    // Column write on load transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < LANES; c++) begin
                r_matrix[c] <= '0;
            end
        end else if (w_fire && (i_in.kind == KIND_LOAD)) begin
            r_matrix[i_in.column_index] <= w_vec;
        end
    end

    // Stage valid bits; a load leaves a bubble
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= w_fire && (i_in.kind == KIND_XFORM);
            end
            if (w_s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    for (genvar r = 0; r < LANES; r++) begin : g_lane
        mvt_lane u_lane (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_coef (w_coef[r]),
            .i_vec  (w_vec),
            .o_res  (w_res[r])
        );
    end

    mvt_merge u_merge (
        .i_res  (w_res),
        .o_word (w_word)
    );

    // Output register: load on advance, hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (w_s2_adv) begin
            r_out_data <= w_word;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.result_0  = r_out_data.results[0];
    assign o_out.result_1  = r_out_data.results[1];
    assign o_out.result_2  = r_out_data.results[2];
    assign o_out.result_3  = r_out_data.results[3];
    assign o_out.saturated = r_out_data.saturated;

`ifndef SYNTHESIS
    // A load into an empty first stage must not create a result
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (i_in.kind == KIND_LOAD) && !r_s1_valid) |=> !r_s1_valid)
        else $error("load transfer produced a pipeline item");

    // A load's value_0 lands in row 0 of the addressed column at once
    a_load_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (i_in.kind == KIND_LOAD)) |=>
        (r_matrix[$past(i_in.column_index)][0] == $past(i_in.value_0)))
        else $error("column write missing");

    // A clipped result carries a full-scale element
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.saturated) |->
        (o_out.result_0 == ELEM_MAX || o_out.result_0 == ELEM_MIN ||
         o_out.result_1 == ELEM_MAX || o_out.result_1 == ELEM_MIN ||
         o_out.result_2 == ELEM_MAX || o_out.result_2 == ELEM_MIN ||
         o_out.result_3 == ELEM_MAX || o_out.result_3 == ELEM_MIN))
        else $error("saturated flag without full-scale element");

    // An empty first stage always accepts
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> i_in.ready)
        else $error("input blocked with empty first stage");
`endif

endmodule

`default_nettype wire

[verif/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mvt_pkg::*;

    // Run shape
    localparam int RANDOM_ITEMS   = 2000;
    localparam int HOLD_CYCLES    = 64;    // long receiver hold-off that backs up the pipe
    localparam int DRAIN_CYCLES   = 10;    // three stages of latency, with margin
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either channel
    localparam int PRESSURE_AT    = 600;
    localparam int PAUSE_AT       = 1200;

    localparam t_elem ONE_Q = 32'sh0001_0000;

    // Bounds of the shifted sum that still fit in one element
    localparam t_sum SUM_HI = 66'sd2147483647;
    localparam t_sum SUM_LO = -66'sd2147483648;

    typedef struct packed {
        logic             kind;
        logic [COL_W-1:0] col;
        t_vec             vals;
    } t_item;

    typedef struct {
        t_item     item;
        bit        typed;   // expectation written into the table
        t_out_word want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mvt_in_if  in_ch();
    mvt_out_if out_ch();

    matrix_vector_transform_4x4_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the stored matrix, indexed [column][row]
    t_elem     col_mem [LANES][LANES];
    t_out_word pending_xforms [$];
    t_row      dir_rows [$];
    int        mismatch_count = 0;
    int        idle_cycles    = 0;
    bit        hold_req       = 1'b0;

    // Multiply the shadow matrix by one vector. Each row sum is exact at
    // full width, then shifted (arithmetic, so it rounds toward minus
    // infinity) and clipped to one element.
    function automatic t_out_word transform_vec(input t_vec v);
        t_out_word res;
        t_prod     prod;
        t_sum      acc;
        t_sum      sh;
        t_elem     a;
        t_elem     b;
        res.saturated = 1'b0;
        for (int r = 0; r < LANES; r++) begin
            acc = '0;
            for (int c = 0; c < LANES; c++) begin
                a    = col_mem[c][r];
                b    = v[c];
                prod = a * b;
                acc  = acc + prod;
            end
            sh = acc >>> FRAC_BITS;
            if (sh > SUM_HI) begin
                res.results[r] = ELEM_MAX;
                res.saturated  = 1'b1;
            end else if (sh < SUM_LO) begin
                res.results[r] = ELEM_MIN;
                res.saturated  = 1'b1;
            end else begin
                res.results[r] = sh[ELEM_W-1:0];
            end
        end
        return res;
    endfunction

    // Mix of full-range words, the extremes, the raw words 0, 1 and -1, and small
    // Q16.16 values that keep most sums inside range.
    function automatic t_elem rand_elem();
        t_elem e;
        case ($urandom_range(0, 9))
            0, 1, 2: e = $urandom;
            3: begin
                case ($urandom_range(0, 4))
                    0:       e = ELEM_MIN;
                    1:       e = ELEM_MAX;
                    2:       e = '0;
                    3:       e = 1;
                    default: e = -1;
                endcase
            end
            default: e = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        endcase
        return e;
    endfunction

    function automatic t_item rand_item();
        t_item it;
        it.kind = ($urandom_range(0, 3) == 0) ? KIND_LOAD : KIND_XFORM;
        it.col  = COL_W'($urandom_range(0, LANES - 1));
        for (int i = 0; i < LANES; i++) begin
            it.vals[i] = rand_elem();
        end
        return it;
    endfunction

    task automatic add_row(input logic kind, input logic [COL_W-1:0] col,
                           input t_elem v0, input t_elem v1, input t_elem v2, input t_elem v3,
                           input bit typed,
                           input t_elem w0, input t_elem w1, input t_elem w2, input t_elem w3,
                           input logic sat);
        t_row row;
        row.item.kind         = kind;
        row.item.col          = col;
        row.item.vals[0]      = v0;
        row.item.vals[1]      = v1;
        row.item.vals[2]      = v2;
        row.item.vals[3]      = v3;
        row.typed             = typed;
        row.want.results[0]   = w0;
        row.want.results[1]   = w1;
        row.want.results[2]   = w2;
        row.want.results[3]   = w3;
        row.want.saturated    = sat;
        dir_rows.push_back(row);
    endtask

    // Call at a falling edge. Hold the item until the transfer, update the
    // shadow matrix or queue the expected result, and return at the next
    // falling edge with valid still high.
    task automatic offer(input t_item it, input bit typed, input t_out_word want);
        in_ch.valid        = 1'b1;
        in_ch.kind         = it.kind;
        in_ch.column_index = it.col;
        in_ch.value_0      = it.vals[0];
        in_ch.value_1      = it.vals[1];
        in_ch.value_2      = it.vals[2];
        in_ch.value_3      = it.vals[3];
        do @(posedge i_clk); while (!in_ch.ready);
        if (it.kind == KIND_LOAD) begin
            for (int r = 0; r < LANES; r++) begin
                col_mem[it.col][r] = it.vals[r];
            end
        end else begin
            pending_xforms.push_back(typed ? want : transform_vec(it.vals));
        end
        @(negedge i_clk);
    endtask

    // Sender: reset, directed table, random bursts, drain, verdict.
    initial begin
        int        n;
        int        burst;
        int        gap;
        bit        pressed;
        bit        paused;
        t_out_word no_want;

        n       = 0;
        pressed = 1'b0;
        paused  = 1'b0;
        no_want = '0;

        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.kind         = KIND_LOAD;
        in_ch.column_index = '0;
        in_ch.value_0      = '0;
        in_ch.value_1      = '0;
        in_ch.value_2      = '0;
        in_ch.value_3      = '0;
        for (int c = 0; c < LANES; c++) begin
            for (int r = 0; r < LANES; r++) begin
                col_mem[c][r] = '0;
            end
        end

        // Directed table. Typed expectations only where the product is
        // obvious; the rest go through the predictor.
        // Matrix is all zero straight out of reset.
        add_row(KIND_XFORM, 0, ELEM_MIN, ELEM_MAX, -1, 1,
                1, 0, 0, 0, 0, 1'b0);
        // Load identity, column by column.
        add_row(KIND_LOAD, 0, ONE_Q, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        add_row(KIND_LOAD, 1, 0, ONE_Q, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        add_row(KIND_LOAD, 2, 0, 0, ONE_Q, 0, 0, 0, 0, 0, 0, 1'b0);
        add_row(KIND_LOAD, 3, 0, 0, 0, ONE_Q, 0, 0, 0, 0, 0, 1'b0);
        // Identity passes the vector through, extremes included.
        add_row(KIND_XFORM, 2, ELEM_MAX, ELEM_MIN, 32'sh0001_8000, -1,
                1, ELEM_MAX, ELEM_MIN, 32'sh0001_8000, -1, 1'b0);
        // Tiny products: the shift rounds toward minus infinity.
        add_row(KIND_LOAD, 0, 1, -1, ELEM_MAX, ELEM_MIN, 0, 0, 0, 0, 0, 1'b0);
        add_row(KIND_XFORM, 0, 1, 0, 0, 0,
                1, 0, -1, 32'sh0000_7FFF, 32'shFFFF_8000, 1'b0);
        // Clip boundary: +2^31 clips, -2^31 just fits.
        add_row(KIND_LOAD, 0, 32'sh0002_0000, 32'sh0002_0000, 32'shFFFE_0000, ONE_Q,
                0, 0, 0, 0, 0, 1'b0);
        add_row(KIND_XFORM, 1, 32'sh4000_0000, 0, 0, 0,
                1, ELEM_MAX, ELEM_MAX, ELEM_MIN, 32'sh4000_0000, 1'b1);
        // Full-scale columns drive every lane into saturation.
        add_row(KIND_LOAD, 0, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX, 0, 0, 0, 0, 0, 1'b0);
        add_row(KIND_LOAD, 1, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN, 0, 0, 0, 0, 0, 1'b0);
        add_row(KIND_XFORM, 0, ELEM_MAX, 0, 0, 0,
                1, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX, 1'b1);
        add_row(KIND_XFORM, 0, ELEM_MIN, 0, 0, 0,
                1, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN, 1'b1);
        add_row(KIND_XFORM, 0, 0, ELEM_MIN, 0, 0,
                1, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX, 1'b1);
        add_row(KIND_LOAD, 2, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN, 0, 0, 0, 0, 0, 1'b0);
        add_row(KIND_LOAD, 3, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX, 0, 0, 0, 0, 0, 1'b0);
        // A sum close to the largest the products can reach, then the most negative one.
        add_row(KIND_XFORM, 3, ELEM_MAX, ELEM_MIN, ELEM_MIN, ELEM_MAX, 0, 0, 0, 0, 0, 1'b0);
        add_row(KIND_XFORM, 0, ELEM_MIN, ELEM_MAX, ELEM_MAX, ELEM_MIN, 0, 0, 0, 0, 0, 1'b0);
        // Terms cancel to a small negative sum.
        add_row(KIND_XFORM, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 1'b0);
        add_row(KIND_XFORM, 2, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1'b0);

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < dir_rows.size(); i++) begin
            offer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random bursts with random gaps; now and then a long unbroken run.
        while (n < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
            if (n >= PRESSURE_AT && !pressed) begin
                // Stall the receiver and keep offering so the pipe backs up.
                pressed  = 1'b1;
                hold_req = 1'b1;
                burst    = 48;
            end
            for (int k = 0; k < burst && n < RANDOM_ITEMS; k++) begin
                offer(rand_item(), 1'b0, no_want);
                n++;
            end
            gap = $urandom_range(0, 12);
            if (n >= PAUSE_AT && !paused) begin
                // Drop valid and let every pending result drain out.
                paused      = 1'b1;
                in_ch.valid = 1'b0;
                while (pending_xforms.size() != 0) @(negedge i_clk);
            end
            if (gap != 0) begin
                in_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        in_ch.valid = 1'b0;

        while (pending_xforms.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Receiver: ready pattern changes every stretch. A hold request from the
    // sender overrides it, holding ready low, and clears when hold_cnt reaches HOLD_CYCLES.
    initial begin
        int span;
        int mode;
        int hold_cnt;
        hold_cnt     = 0;
        out_ch.ready = 1'b0;
        forever begin
            span = $urandom_range(20, 200);
            mode = $urandom_range(0, 3);
            repeat (span) begin
                @(negedge i_clk);
                if (hold_req) begin
                    out_ch.ready = 1'b0;
                    hold_cnt++;
                    if (hold_cnt == HOLD_CYCLES) begin
                        hold_req = 1'b0;
                        hold_cnt = 0;
                    end
                end else begin
                    case (mode)
                        0:       out_ch.ready = 1'b1;
                        1:       out_ch.ready = 1'($urandom_range(0, 1));
                        2:       out_ch.ready = ($urandom_range(0, 3) == 0);
                        default: out_ch.ready = ~out_ch.ready;
                    endcase
                end
            end
        end
    end

    // Check every output transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_word got;
        t_out_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.results[0] = out_ch.result_0;
            got.results[1] = out_ch.result_1;
            got.results[2] = out_ch.result_2;
            got.results[3] = out_ch.result_3;
            got.saturated  = out_ch.saturated;
            if (pending_xforms.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                mismatch_count++;
            end else begin
                want = pending_xforms.pop_front();
                for (int r = 0; r < LANES; r++) begin
                    if (got.results[r] !== want.results[r]) begin
                        $display("%0t: result_%0d expected %h actual %h",
                                 $time, r, want.results[r], got.results[r]);
                        mismatch_count++;
                    end
                end
                if (got.saturated !== want.saturated) begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, want.saturated, got.saturated);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
